### hdl/xld_pkg.sv
// Package for the XOR-LRC frame deframer.
// Holds the result type, phase type, status codes and type-byte decode.
// No dependencies.
package xld_pkg;

    localparam logic [20:0] MAX_BODY_RESET = 21'd1048580;

    localparam logic [7:0] TYPE_P = 8'd80;
    localparam logic [7:0] TYPE_C = 8'd67;
    localparam logic [7:0] TYPE_T = 8'd84;
    localparam logic [7:0] TYPE_Z = 8'd90;
    localparam logic [7:0] TYPE_B = 8'd66;
    localparam logic [7:0] TYPE_X = 8'd88;
    localparam logic [7:0] TYPE_H = 8'd72;
    localparam logic [7:0] MSG_ERROR = 8'd69;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_LRC   = 3'd3;
    localparam logic [2:0] ST_EMPTY_ERR = 3'd4;

    localparam logic [2:0] REG_MAX_BODY = 3'd0;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_HDR,
        PH_PAYLOAD,
        PH_LRC
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [2:0] status;
        logic [7:0] frame_type;
        logic [7:0] destination;
        logic [7:0] sender;
        logic [7:0] command_code;
        logic [7:0] message_code;
        logic       compressed;
    } t_result;

    function automatic logic [2:0] len_width(input logic [7:0] t);
        logic [2:0] w;
        case (t)
            TYPE_P: w = 3'd1;
            TYPE_C, TYPE_T, TYPE_Z: w = 3'd2;
            TYPE_B, TYPE_X, TYPE_H: w = 3'd4;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

### hdl/xld_parser.sv
// Frame parser: phase machine, length/header capture, LRC check, result build.
// Depends on xld_pkg.
module xld_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic [20:0]      i_max_body,
    output logic             o_res_valid,
    output xld_pkg::t_result o_res
);
    import xld_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [2:0]  r_left, n_left;
    logic [31:0] r_len, n_len;
    logic [20:0] r_count, n_count;
    logic [7:0]  r_lrc, n_lrc;
    logic [7:0]  r_hdr [4];
    logic [7:0]  n_hdr [4];

    logic [2:0]  type_w;
    logic [2:0]  cur_w;
    logic [1:0]  len_pos;
    logic [1:0]  hdr_pos;
    logic [31:0] len_shift;
    logic        len_bad;
    logic [20:0] body_left;

    assign type_w    = len_width(i_byte);
    assign cur_w     = len_width(r_type);
    assign len_pos   = 2'(cur_w - r_left);
    assign hdr_pos   = 2'(3'd4 - r_left);
    assign len_shift = {24'd0, i_byte} << {len_pos, 3'b000};
    assign len_bad   = (n_len < 32'd4) || (n_len > {11'd0, i_max_body});
    assign body_left = r_len[20:0] - 21'd4;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_TYPE: begin
                if (type_w != 3'd0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (r_left == 3'd1) begin
                    n_phase = len_bad ? PH_TYPE : PH_HDR;
                end
            end
            PH_HDR: begin
                if (r_left == 3'd1) begin
                    n_phase = (body_left == 21'd0) ? PH_LRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_count == 21'd1) begin
                    n_phase = PH_LRC;
                end
            end
            PH_LRC: begin
                n_phase = PH_TYPE;
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase
    end

    always_comb begin
        n_type  = r_type;
        n_left  = r_left;
        n_len   = r_len;
        n_count = r_count;
        n_lrc   = r_lrc;
        n_hdr   = r_hdr;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_TYPE: begin
                n_type  = i_byte;
                n_len   = '0;
                n_count = '0;
                n_lrc   = '0;
                n_left  = type_w;
                for (int k = 0; k < 4; k++) begin
                    n_hdr[k] = '0;
                end
                if (type_w == 3'd0) begin
                    o_res_valid = 1'b1;
                    o_res.frame_end = 1'b1;
                    o_res.status    = ST_BAD_TYPE;
                end
            end
            PH_LEN: begin
                n_lrc  = r_lrc ^ i_byte;
                n_len  = r_len | len_shift;
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    n_left = 3'd4;
                    if (len_bad) begin
                        o_res_valid = 1'b1;
                        o_res.frame_end = 1'b1;
                        o_res.status    = ST_BAD_LEN;
                    end
                end
            end
            PH_HDR: begin
                n_lrc  = r_lrc ^ i_byte;
                n_hdr[hdr_pos] = i_byte;
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    n_count = body_left;
                end
            end
            PH_PAYLOAD: begin
                n_lrc   = r_lrc ^ i_byte;
                n_count = r_count - 21'd1;
                o_res_valid = 1'b1;
                o_res.payload_byte = i_byte;
                o_res.byte_valid   = 1'b1;
            end
            PH_LRC: begin
                o_res_valid = 1'b1;
                o_res.frame_end = 1'b1;
                if ((r_lrc ^ i_byte) != 8'd0) begin
                    o_res.status = ST_BAD_LRC;
                end else if (r_hdr[3] == MSG_ERROR && r_len == 32'd4) begin
                    o_res.status = ST_EMPTY_ERR;
                end else begin
                    o_res.status = ST_OK;
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        o_res.frame_type   = n_type;
        o_res.destination  = n_hdr[0];
        o_res.sender       = n_hdr[1];
        o_res.command_code = n_hdr[2];
        o_res.message_code = n_hdr[3];
        o_res.compressed   = (n_type == TYPE_Z) || (n_type == TYPE_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_type  <= '0;
            r_left  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_lrc   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_left  <= n_left;
            r_len   <= n_len;
            r_count <= n_count;
            r_lrc   <= n_lrc;
            r_hdr   <= n_hdr;
        end
    end

endmodule

### hdl/xld_outbuf.sv
// Output register with one skid entry for the result channel.
// Depends on xld_pkg.
module xld_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  xld_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output xld_pkg::t_result o_data,
    input  logic             i_stall
);
    import xld_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!out_free && i_push && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

### hdl/xld_config.sv
// APB-style register port holding the largest accepted length field.
// Depends on xld_pkg.
module xld_config (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [20:0] o_max_body
);
    import xld_pkg::*;

    logic [20:0] r_max_body;
    logic        reg_hit;

    assign reg_hit    = (paddr[2] == REG_MAX_BODY[0]);
    assign pready     = 1'b1;
    assign prdata     = reg_hit ? {11'd0, r_max_body} : 32'd0;
    assign o_max_body = r_max_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_max_body <= pwdata[20:0];
        end
    end

endmodule

### hdl/xor_lrc_frame_deframer.sv
// Top level of the XOR-LRC frame deframer.
// Depends on xld_pkg, xld_config, xld_parser, xld_outbuf.
//
// Usage:
//   Input channel: one received byte per transaction on i_rx_byte, taken when
//   i_valid is high and o_stall is low. Output channel: one result per
//   transaction (payload byte, or frame end with status and header fields),
//   taken when o_valid is high and i_stall is low. Valid type, in-range length
//   and header bytes produce no result; a bad type or length ends the frame.
//   Each result is registered in the output register, or in the skid entry
//   while that register is stalled. Throughput: one byte per cycle while
//   o_stall is low, set by the parser update from input byte to output register.
//   Stall: the output register plus one skid entry absorb results; o_stall
//   rises once the skid entry is occupied and falls when it drains.
//   Reset (i_rst_n low, synchronous): parser waits for a type byte, both
//   output entries empty, max_body returns to 1048580.
//   Configuration: max_body at byte address 0; the user must write it only while idle, the block does not enforce this.
module xor_lrc_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_frame_end,
    output logic [2:0]  o_status,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_destination,
    output logic [7:0]  o_sender,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_message_code,
    output logic        o_compressed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xld_pkg::*;

    logic [20:0] max_body;
    logic        accept;
    logic        res_valid;
    t_result     res;
    t_result     out_res;
    logic        buf_full;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    xld_config u_config (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_body (max_body)
    );

    xld_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx_byte),
        .i_max_body  (max_body),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xld_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_stall (i_stall)
    );

    assign o_payload_byte = out_res.payload_byte;
    assign o_byte_valid   = out_res.byte_valid;
    assign o_frame_end    = out_res.frame_end;
    assign o_status       = out_res.status;
    assign o_frame_type   = out_res.frame_type;
    assign o_destination  = out_res.destination;
    assign o_sender       = out_res.sender;
    assign o_command_code = out_res.command_code;
    assign o_message_code = out_res.message_code;
    assign o_compressed   = out_res.compressed;

`ifndef SYNTHESIS
    a_byte_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> !o_frame_end)
        else $error("payload byte flagged as frame end");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> o_status == ST_OK)
        else $error("nonzero status outside frame end");

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry held while output register empty");

    a_skid_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_stall) && o_stall |-> $past(i_stall) && $past(o_valid))
        else $error("skid entry filled without a downstream stall");
`endif

endmodule
